### sv/coo_pkg.sv
package coo_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = 39;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_SORTR = 6'b000010,
    ST_SORTC = 6'b000100,
    ST_MERGE = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  function automatic val_t sat_q16(input acc_t s);
    acc_t hi;
    acc_t lo;
    begin
      hi = acc_t'(32'sh7FFFFFFF);
      lo = ~hi;
      if (s > hi) begin
        sat_q16 = val_t'(32'h7FFFFFFF);
      end else if (s < lo) begin
        sat_q16 = val_t'(32'h80000000);
      end else begin
        sat_q16 = val_t'(s[VAL_W-1:0]);
      end
    end
  endfunction

endpackage

### sv/coo_sort_and_merge_duplicates_core.sv
// channel  | ports                                        | direction
// input    | start, busy, in_row_index, in_col_index,     | in (busy out)
//          | in_entry_value, in_final_entry               |
// result   | out_valid, out_row, out_col, out_value,      | out
//          | out_last                                     |
// one transaction is taken per cycle while loading
// after the final transaction a selection sort rescans all n entries for every sorted
// slot, then merge, emit and done follow in that order
// busy is high for that whole stretch; the last result shows in the same cycle as busy drops
// reset is synchronous on rst_n and empties the store; memory contents need no clearing
// the receiver cannot stall, so each result shows for one cycle with out_valid high
module coo_sort_and_merge_duplicates_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int INDEX_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_row_index,
  input  logic [15:0] in_col_index,
  input  logic [31:0] in_entry_value,
  input  logic        in_final_entry,
  output logic        out_valid,
  output logic [15:0] out_row,
  output logic [15:0] out_col,
  output logic [31:0] out_value,
  output logic        out_last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int MW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam logic [15:0] CMASK = 16'((32'd1 << MW) - 32'd1);

  // store: entries loaded in arrival order, selection sort writes a second memory
  logic [63:0] mem_a [MAX_ENTRIES];
  logic [63:0] mem_b [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] used_r, used_nxt;

  coo_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] out_i_r, out_i_nxt;    // sorted output slot being filled
  logic [CW-1:0] scan_r, scan_nxt;      // scan pointer
  logic [AW-1:0] best_r, best_nxt;
  logic [31:0]   bkey_r, bkey_nxt;
  logic          bval_r, bval_nxt;
  logic [63:0]   rd_a, rd_b;
  logic          rd_ok_r, rd_ok_nxt;    // rd_a holds scan_r-1
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          wa_en, wb_en;
  logic [AW-1:0] wa_addr, wb_addr, ra_addr, rb_addr;
  logic [63:0]   wa_data, wb_data;

  // merge state
  logic [31:0]        mkey_r, mkey_nxt;
  coo_pkg::acc_t      macc_r, macc_nxt;
  logic               mhave_r, mhave_nxt;
  logic               pend_r, pend_nxt;   // one merged entry waiting to go out
  logic [31:0]        pkey_r, pkey_nxt;
  coo_pkg::val_t      pval_r, pval_nxt;
  logic               ov_r, ov_nxt;
  logic               ol_r, ol_nxt;
  logic [31:0]        okey_r, okey_nxt;
  coo_pkg::val_t      oval_r, oval_nxt;
  logic               bread_r, bread_nxt; // rd_b valid for slot scan_r-1

  coo_pkg::val_t      rv;
  coo_pkg::val_t      sv;
  coo_pkg::val_t      cur_sum;
  logic               take;

  always_ff @(posedge clk) begin
    if (wa_en) begin
      mem_a[wa_addr] <= wa_data;
    end
    rd_a <= mem_a[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem_b[wb_addr] <= wb_data;
    end
    rd_b <= mem_b[rb_addr];
  end

  assign take = start && !busy;
  assign busy = (st_r != coo_pkg::ST_LOAD);
  assign rv   = coo_pkg::val_t'(rd_b[31:0]);
  assign cur_sum = coo_pkg::sat_q16(macc_r);
  assign sv   = cur_sum;

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    out_i_nxt  = out_i_r;
    scan_nxt   = scan_r;
    best_nxt   = best_r;
    bkey_nxt   = bkey_r;
    bval_nxt   = bval_r;
    rd_ok_nxt  = 1'b0;
    rd_idx_nxt = rd_idx_r;
    used_nxt   = used_r;
    mkey_nxt   = mkey_r;
    macc_nxt   = macc_r;
    mhave_nxt  = mhave_r;
    pend_nxt   = pend_r;
    pkey_nxt   = pkey_r;
    pval_nxt   = pval_r;
    ov_nxt     = 1'b0;
    ol_nxt     = 1'b0;
    okey_nxt   = okey_r;
    oval_nxt   = oval_r;
    bread_nxt  = 1'b0;
    wa_en      = 1'b0;
    wa_addr    = cnt_r[AW-1:0];
    wa_data    = {in_row_index & CMASK, in_col_index & CMASK, in_entry_value};
    wb_en      = 1'b0;
    wb_addr    = out_i_r[AW-1:0];
    wb_data    = rd_a;
    ra_addr    = scan_r[AW-1:0];
    rb_addr    = scan_r[AW-1:0];

    unique case (st_r)
      coo_pkg::ST_LOAD: begin
        if (take) begin
          if (cnt_r < CW'(MAX_ENTRIES)) begin
            wa_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_final_entry) begin
            st_nxt    = coo_pkg::ST_SORTR;
            out_i_nxt = '0;
            scan_nxt  = '0;
            bval_nxt  = 1'b0;
            used_nxt  = '0;
          end
        end
      end
      // scan all unused entries, keep the smallest key, earliest index on ties
      coo_pkg::ST_SORTR: begin
        if (out_i_r == cnt_r) begin
          st_nxt    = coo_pkg::ST_MERGE;
          scan_nxt  = '0;
          mhave_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end else begin
          if (rd_ok_r && !used_r[rd_idx_r] &&
              (!bval_r || rd_a[63:32] < bkey_r)) begin
            bval_nxt = 1'b1;
            bkey_nxt = rd_a[63:32];
            best_nxt = rd_idx_r;
          end
          if (scan_r < cnt_r) begin
            ra_addr    = scan_r[AW-1:0];
            rd_ok_nxt  = 1'b1;
            rd_idx_nxt = scan_r[AW-1:0];
            scan_nxt   = scan_r + CW'(1);
          end else if (!rd_ok_r) begin
            ra_addr  = best_r;
            st_nxt   = coo_pkg::ST_SORTC;
          end
        end
      end
      coo_pkg::ST_SORTC: begin
        // rd_a holds the chosen entry
        wb_en            = 1'b1;
        used_nxt[best_r] = 1'b1;
        out_i_nxt        = out_i_r + CW'(1);
        scan_nxt         = '0;
        bval_nxt         = 1'b0;
        st_nxt           = coo_pkg::ST_SORTR;
      end
      // walk mem_b, fold equal keys, drop zero sums, hold one entry back to mark last
      coo_pkg::ST_MERGE: begin
        if (bread_r) begin
          if (mhave_r && rd_b[63:32] == mkey_r) begin
            macc_nxt = macc_r + coo_pkg::acc_t'(rv);
          end else begin
            if (mhave_r && sv != '0) begin
              if (pend_r) begin
                ov_nxt   = 1'b1;
                okey_nxt = pkey_r;
                oval_nxt = pval_r;
              end
              pend_nxt = 1'b1;
              pkey_nxt = mkey_r;
              pval_nxt = sv;
            end
            mhave_nxt = 1'b1;
            mkey_nxt  = rd_b[63:32];
            macc_nxt  = coo_pkg::acc_t'(rv);
          end
        end
        if (scan_r < cnt_r) begin
          rb_addr   = scan_r[AW-1:0];
          bread_nxt = 1'b1;
          scan_nxt  = scan_r + CW'(1);
        end else if (!bread_r) begin
          st_nxt = coo_pkg::ST_EMIT;
        end
      end
      coo_pkg::ST_EMIT: begin
        if (mhave_r && sv != '0) begin
          if (pend_r) begin
            ov_nxt   = 1'b1;
            okey_nxt = pkey_r;
            oval_nxt = pval_r;
          end
          pend_nxt = 1'b1;
          pkey_nxt = mkey_r;
          pval_nxt = sv;
        end
        mhave_nxt = 1'b0;
        st_nxt    = coo_pkg::ST_DONE;
      end
      coo_pkg::ST_DONE: begin
        if (pend_r) begin
          ov_nxt   = 1'b1;
          ol_nxt   = 1'b1;
          okey_nxt = pkey_r;
          oval_nxt = pval_r;
        end
        pend_nxt = 1'b0;
        cnt_nxt  = '0;
        st_nxt   = coo_pkg::ST_LOAD;
      end
      default: st_nxt = coo_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= coo_pkg::ST_LOAD;
      cnt_r   <= '0;
      rd_ok_r <= 1'b0;
      bread_r <= 1'b0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      mhave_r <= 1'b0;
      bval_r  <= 1'b0;
      used_r  <= '0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      rd_ok_r <= rd_ok_nxt;
      bread_r <= bread_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      mhave_r <= mhave_nxt;
      bval_r  <= bval_nxt;
      used_r  <= used_nxt;
    end
    out_i_r  <= out_i_nxt;
    scan_r   <= scan_nxt;
    best_r   <= best_nxt;
    bkey_r   <= bkey_nxt;
    rd_idx_r <= rd_idx_nxt;
    mkey_r   <= mkey_nxt;
    macc_r   <= macc_nxt;
    pkey_r   <= pkey_nxt;
    pval_r   <= pval_nxt;
    ol_r     <= ol_nxt;
    okey_r   <= okey_nxt;
    oval_r   <= oval_nxt;
  end

  assign out_valid = ov_r;
  assign out_last  = ol_r;
  assign out_row   = okey_r[31:16];
  assign out_col   = okey_r[15:0];
  assign out_value = oval_r;

endmodule
